@@ rtl/core/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, codes and defaults for the sorted-chain hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int POOL_ENTRIES_DEF = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int DATA_BITS_DEF    = 32;

    // width of the bucket_count field as written on the config port
    localparam int CFG_W    = 9;
    localparam int APB_DW   = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        M_INSERT = 2'd0,
        M_LOOKUP = 2'd1,
        M_REMOVE = 2'd2,
        M_FLUSH  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_SAME    = 3'd1,
        ST_DIFFER  = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_HWAIT,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_ALLOC,
        S_AWAIT,
        S_WNODE,
        S_WLINK,
        S_RL1,
        S_RL2,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch a new transaction, start the modulo
        logic div_step;    // one remainder bit
        logic head_rd;     // read bucket head
        logic head_take;   // start the walk from the head
        logic walk_nil;    // walk ran off the chain
        logic node_rd;     // read node at cur
        logic stop;        // node key >= key: keep cur
        logic advance;     // step to next node
        logic mark_full;   // no node to allocate
        logic alloc_rd;    // read link of free-list head
        logic alloc_take;  // pop free list
        logic take_fresh;  // take next never-used node
        logic wr_node;     // write new node
        logic wr_link_ins; // hook new node into chain
        logic rm_unlink;   // unhook removed node
        logic rm_free;     // push removed node onto free list
        logic finish;      // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_mode mode;
        logic  div_done;
        logic  walk_end;
        logic  key_ge;
        logic  hit;
        logic  free_avail;
        logic  fresh_avail;
        logic  out_busy;
    } t_dp_sts;

endpackage

@@ rtl/core/cht_if.sv @@
// ----------------------------------------------------------------------------
// cht_req_if / cht_rsp_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface cht_req_if #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
);
    import cht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data_word;

    modport source (output valid, mode, key, data_word, input ready);
    modport sink   (input valid, mode, key, data_word, output ready);
endinterface

interface cht_rsp_if #(
    parameter int DATA_BITS = 32,
    parameter int CNT_W     = 11,
    parameter int OCC_W     = 9
);
    import cht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [DATA_BITS-1:0] found_data;
    logic [CNT_W-1:0]     entry_total;
    logic [OCC_W-1:0]     occupied_buckets;

    modport source (output valid, status, found_data, entry_total, occupied_buckets,
                    input ready);
    modport sink   (input valid, status, found_data, entry_total, occupied_buckets,
                    output ready);
endinterface

@@ rtl/core/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer: modulo, chain walk, allocate/link/unlink, result handoff.
// ----------------------------------------------------------------------------
module cht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_mode,
    input  cht_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output cht_pkg::t_dp_cmd o_cmd
);
    import cht_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_mode'(i_in_mode) == M_FLUSH) ? S_FIN : S_DIV;
                end
            end
            S_DIV:   if (i_sts.div_done) n_state = S_HEAD;
            S_HEAD:  n_state = S_HWAIT;
            S_HWAIT: n_state = S_RD;
            S_RD:    n_state = i_sts.walk_end ? S_DECIDE : S_CMP;
            S_CMP:   n_state = i_sts.key_ge ? S_DECIDE : S_RD;
            S_DECIDE: begin
                unique case (i_sts.mode)
                    M_INSERT: begin
                        if (i_sts.hit)              n_state = S_FIN;
                        else if (i_sts.free_avail)  n_state = S_ALLOC;
                        else if (i_sts.fresh_avail) n_state = S_WNODE;
                        else                        n_state = S_FIN;
                    end
                    M_REMOVE: n_state = i_sts.hit ? S_RL1 : S_FIN;
                    default:  n_state = S_FIN;
                endcase
            end
            S_ALLOC: n_state = S_AWAIT;
            S_AWAIT: n_state = S_WNODE;
            S_WNODE: n_state = S_WLINK;
            S_WLINK: n_state = S_FIN;
            S_RL1:   n_state = S_RL2;
            S_RL2:   n_state = S_FIN;
            S_FIN:   if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load      = accept;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_HEAD:  o_cmd.head_rd   = 1'b1;
            S_HWAIT: o_cmd.head_take = 1'b1;
            S_RD: begin
                o_cmd.walk_nil = i_sts.walk_end;
                o_cmd.node_rd  = !i_sts.walk_end;
            end
            S_CMP: begin
                o_cmd.stop    = i_sts.key_ge;
                o_cmd.advance = !i_sts.key_ge;
            end
            S_DECIDE: begin
                if (i_sts.mode == M_INSERT && !i_sts.hit && !i_sts.free_avail) begin
                    o_cmd.take_fresh = i_sts.fresh_avail;
                    o_cmd.mark_full  = !i_sts.fresh_avail;
                end
            end
            S_ALLOC: o_cmd.alloc_rd    = 1'b1;
            S_AWAIT: o_cmd.alloc_take  = 1'b1;
            S_WNODE: o_cmd.wr_node     = 1'b1;
            S_WLINK: o_cmd.wr_link_ins = 1'b1;
            S_RL1:   o_cmd.rm_unlink   = 1'b1;
            S_RL2:   o_cmd.rm_free     = 1'b1;
            S_FIN:   o_cmd.finish      = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/cht_dp.sv @@
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: bit-serial modulo, head/node memories, free list, counts, result.
// ----------------------------------------------------------------------------
module cht_dp #(
    parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = cht_pkg::POOL_ENTRIES_DEF,
    parameter int KEY_BITS     = cht_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS    = cht_pkg::DATA_BITS_DEF,
    parameter int PTR_W        = $clog2(POOL_ENTRIES + 1),
    parameter int BC_W         = $clog2(MAX_BUCKETS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cht_pkg::t_dp_cmd              i_cmd,
    output cht_pkg::t_dp_sts              o_sts,
    input  logic [BC_W-1:0]               i_bucket_count,
    input  logic [1:0]                    i_mode,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [DATA_BITS-1:0]          i_data_word,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [cht_pkg::STATUS_W-1:0]  o_status,
    output logic [DATA_BITS-1:0]          o_found_data,
    output logic [PTR_W-1:0]              o_entry_total,
    output logic [BC_W-1:0]               o_occupied_buckets
);
    import cht_pkg::*;

    localparam int IDX_W = $clog2(POOL_ENTRIES);
    localparam int BI_W  = $clog2(MAX_BUCKETS);
    localparam int CNT_W = $clog2(KEY_BITS);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    // memories
    logic [PTR_W-1:0]     head_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0]  key_mem  [POOL_ENTRIES];
    logic [DATA_BITS-1:0] val_mem  [POOL_ENTRIES];
    logic [PTR_W-1:0]     link_mem [POOL_ENTRIES];
    logic [MAX_BUCKETS-1:0] r_head_vld;

    // transaction
    t_mode                r_mode;
    logic [KEY_BITS-1:0]  r_key, r_sh;
    logic [DATA_BITS-1:0] r_data;
    logic [CNT_W-1:0]     r_cnt;
    logic [BC_W-1:0]      r_rem;

    // walk
    logic [PTR_W-1:0]     r_cur, r_prev, r_steps, r_link_cur;
    logic [DATA_BITS-1:0] r_val_cur;
    logic                 r_hit, r_full, r_was_empty;
    logic [IDX_W-1:0]     r_n;

    // registered reads
    logic [PTR_W-1:0]     r_head_q;
    logic                 r_head_vq;
    logic [KEY_BITS-1:0]  r_nkey_q;
    logic [DATA_BITS-1:0] r_nval_q;
    logic [PTR_W-1:0]     r_nlink_q;

    // pool state and counts
    logic [PTR_W-1:0]     r_free, r_fresh, r_entries;
    logic [BC_W-1:0]      r_used;

    // result register
    logic                 r_out_vld;
    t_status              r_status;
    logic [DATA_BITS-1:0] r_found;
    logic [PTR_W-1:0]     r_out_entries;
    logic [BC_W-1:0]      r_out_used;

    logic [BC_W:0]        div_t;
    logic                 div_ge;
    logic [BI_W-1:0]      bucket;
    logic                 prev_nil;
    logic                 link_we;
    logic [IDX_W-1:0]     link_wa, link_ra;
    logic [PTR_W-1:0]     link_wd;
    logic                 head_we;
    logic [PTR_W-1:0]     head_wd;
    t_status              n_status;
    logic [DATA_BITS-1:0] n_found;

    assign div_t    = {r_rem, r_sh[KEY_BITS-1]};
    assign div_ge   = (div_t >= {1'b0, i_bucket_count});
    assign bucket   = r_rem[BI_W-1:0];
    assign prev_nil = (r_prev >= NIL);

    assign o_sts.mode        = r_mode;
    assign o_sts.div_done    = (r_cnt == CNT_W'(KEY_BITS - 1));
    assign o_sts.walk_end    = (r_cur >= NIL) || (r_steps >= NIL);
    assign o_sts.key_ge      = (r_nkey_q >= r_key);
    assign o_sts.hit         = r_hit;
    assign o_sts.free_avail  = (r_free < NIL);
    assign o_sts.fresh_avail = (r_fresh < NIL);
    assign o_sts.out_busy    = r_out_vld && !i_out_ready;

    // link memory write port
    always_comb begin
        link_we = 1'b0;
        link_wa = r_cur[IDX_W-1:0];
        link_wd = r_cur;
        if (i_cmd.wr_node) begin
            link_we = 1'b1;
            link_wa = r_n;
            link_wd = r_cur;
        end else if (i_cmd.wr_link_ins) begin
            link_we = !prev_nil;
            link_wa = r_prev[IDX_W-1:0];
            link_wd = PTR_W'(r_n);
        end else if (i_cmd.rm_unlink) begin
            link_we = !prev_nil;
            link_wa = r_prev[IDX_W-1:0];
            link_wd = r_link_cur;
        end else if (i_cmd.rm_free) begin
            link_we = 1'b1;
            link_wa = r_cur[IDX_W-1:0];
            link_wd = r_free;
        end
    end

    assign link_ra = i_cmd.alloc_rd ? r_free[IDX_W-1:0] : r_cur[IDX_W-1:0];
    assign head_we = (i_cmd.wr_link_ins || i_cmd.rm_unlink) && prev_nil;
    assign head_wd = i_cmd.wr_link_ins ? PTR_W'(r_n) : r_link_cur;

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (i_cmd.node_rd || i_cmd.alloc_rd) begin
            r_nlink_q <= link_mem[link_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_node) begin
            key_mem[r_n] <= r_key;
            val_mem[r_n] <= r_data;
        end
        if (i_cmd.node_rd) begin
            r_nkey_q <= key_mem[r_cur[IDX_W-1:0]];
            r_nval_q <= val_mem[r_cur[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[bucket] <= head_wd;
        end
        if (i_cmd.head_rd) begin
            r_head_q  <= head_mem[bucket];
            r_head_vq <= r_head_vld[bucket];
        end
    end

    // transaction, modulo and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_key;
            r_sh   <= i_key;
            r_data <= i_data_word;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_hit  <= 1'b0;
            r_full <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_sh  <= r_sh << 1;
            r_cnt <= r_cnt + 1'b1;
            r_rem <= div_ge ? BC_W'(div_t - {1'b0, i_bucket_count}) : BC_W'(div_t);
        end
        if (i_cmd.head_take) begin
            r_cur       <= r_head_vq ? r_head_q : NIL;
            r_was_empty <= !r_head_vq || (r_head_q >= NIL);
            r_prev      <= NIL;
            r_steps     <= '0;
        end
        if (i_cmd.walk_nil) begin
            r_cur <= NIL;
            r_hit <= 1'b0;
        end
        if (i_cmd.stop) begin
            r_hit      <= (r_nkey_q == r_key);
            r_val_cur  <= r_nval_q;
            r_link_cur <= r_nlink_q;
        end
        if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_nlink_q;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.mark_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.alloc_take) begin
            r_n <= r_free[IDX_W-1:0];
        end
        if (i_cmd.take_fresh) begin
            r_n <= r_fresh[IDX_W-1:0];
        end
    end

    // pool and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= NIL;
            r_fresh    <= '0;
            r_entries  <= '0;
            r_used     <= '0;
            r_head_vld <= '0;
        end else begin
            if (i_cmd.alloc_take) begin
                r_free <= r_nlink_q;
            end
            if (i_cmd.take_fresh) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (head_we) begin
                r_head_vld[bucket] <= 1'b1;
            end
            if (i_cmd.wr_link_ins) begin
                r_entries <= r_entries + 1'b1;
                if (r_was_empty) begin
                    r_used <= r_used + 1'b1;
                end
            end
            if (i_cmd.rm_unlink) begin
                if (r_entries != '0) begin
                    r_entries <= r_entries - 1'b1;
                end
                if (prev_nil && (r_link_cur >= NIL) && (r_used != '0)) begin
                    r_used <= r_used - 1'b1;
                end
            end
            if (i_cmd.rm_free) begin
                r_free <= r_cur;
            end
            if (i_cmd.finish && r_mode == M_FLUSH) begin
                r_free     <= NIL;
                r_fresh    <= '0;
                r_entries  <= '0;
                r_used     <= '0;
                r_head_vld <= '0;
            end
        end
    end

    // result
    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        case (r_mode) inside
            M_INSERT: begin
                if (r_hit)       n_status = (r_val_cur == r_data) ? ST_SAME : ST_DIFFER;
                else if (r_full) n_status = ST_FULL;
            end
            M_LOOKUP, M_REMOVE: begin
                if (r_hit) n_found  = r_val_cur;
                else       n_status = ST_MISSING;
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status      <= n_status;
            r_found       <= n_found;
            r_out_entries <= (r_mode == M_FLUSH) ? '0 : r_entries;
            r_out_used    <= (r_mode == M_FLUSH) ? '0 : r_used;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_status           = r_status;
    assign o_found_data       = r_found;
    assign o_entry_total      = r_out_entries;
    assign o_occupied_buckets = r_out_used;

endmodule

@@ rtl/core/chained_hash_table_sorted_chains.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_chains
// Key/data table with per-bucket chains held in ascending key order.
// ----------------------------------------------------------------------------
// One operation (insert, lookup, remove, flush) is taken at a time and gives
// one result transaction. The bucket is key mod bucket_count, formed by a
// bit-serial remainder unit at one key bit per cycle. The chain walk then
// reads each visited node and compares its key in separate states, because
// the node memories have one registered read port. A flush skips the
// modulo and the walk; a remove of a present key then unlinks and frees the
// node, and an insert of a new key takes a free-list or fresh node, if
// any is left, then writes and links it. A finished result waits in an
// output register; while that register is still full the sequencer holds in
// its last state. The next request is taken in the cycle after the result
// is loaded. No clearing pass is needed after reset: bucket heads carry
// valid bits that reset and flush clear at once, and node storage is only
// read along live links. bucket_count is at APB byte address 0; only the
// low CFG_W bits of a write are used, zero reads back as 1 and values above
// MAX_BUCKETS are clamped. Write it only while the block is idle; existing
// chains stay where they are.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted_chains #(
    parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = cht_pkg::POOL_ENTRIES_DEF,
    parameter int KEY_BITS     = cht_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS    = cht_pkg::DATA_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cht_req_if.sink                    i_req,
    cht_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       paddr,
    input  logic [cht_pkg::APB_DW-1:0] pwdata,
    output logic [cht_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import cht_pkg::*;

    localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
    localparam int BC_W  = $clog2(MAX_BUCKETS + 1);

    // config register: bucket_count, clamped to 1..MAX_BUCKETS on write
    logic [BC_W-1:0]  r_bucket_count;
    logic [CFG_W-1:0] cfg_val;
    logic             cfg_we;

    assign pready  = 1'b1;
    assign cfg_val = pwdata[CFG_W-1:0];
    assign cfg_we  = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata  = APB_DW'(r_bucket_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BC_W'(MAX_BUCKETS);
        end else if (cfg_we) begin
            if (cfg_val == '0) begin
                r_bucket_count <= BC_W'(1);
            end else if (32'(cfg_val) > 32'(MAX_BUCKETS)) begin
                r_bucket_count <= BC_W'(MAX_BUCKETS);
            end else begin
                r_bucket_count <= BC_W'(cfg_val);
            end
        end
    end

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_mode  (i_req.mode),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    // memories, walk registers, counts, result register
    cht_dp #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .DATA_BITS    (DATA_BITS),
        .PTR_W        (PTR_W),
        .BC_W         (BC_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_bucket_count     (r_bucket_count),
        .i_mode             (i_req.mode),
        .i_key              (i_req.key),
        .i_data_word        (i_req.data_word),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status           (o_rsp.status),
        .o_found_data       (o_rsp.found_data),
        .o_entry_total      (o_rsp.entry_total),
        .o_occupied_buckets (o_rsp.occupied_buckets)
    );

endmodule

@@ verif/chained_hash_table_sorted_chains_tb.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_chains_tb
// Self-checking bench for the sorted-chain hash table.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the table (bucket heads, node pool,
// free list, counts) and predicts every result. Directed operations cover key
// and data extremes, ordered chain insertion, flush and every status but full;
// a pool-exhaustion pass follows. Random phases under a range of bucket counts,
// clamped ones included, have random gaps on both channels in all but phase 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_table_sorted_chains_tb;
    import cht_pkg::*;

    localparam int NBUCKET = 256;
    localparam int NPOOL   = 1024;
    localparam logic [10:0] NIL = 11'(NPOOL);

    typedef struct packed {
        t_status     status;
        logic [31:0] found_data;
        logic [10:0] entry_total;
        logic [8:0]  occupied_buckets;
    } t_result;

    // Table predictor and result checker.
    class table_scoreboard;
        logic [10:0] head[NBUCKET];
        logic [31:0] nkey[NPOOL];
        logic [31:0] nval[NPOOL];
        logic [10:0] nlink[NPOOL];
        int unsigned free_head, fresh, entries, used, buckets;
        t_result     expected_q[$];
        int          errors;
        int          status_seen[5];
        int          checked;

        function void clear_table();
            foreach (head[b]) head[b] = NIL;
            free_head = NIL;
            fresh     = 0;
            entries   = 0;
            used      = 0;
        endfunction

        function void init();
            buckets = NBUCKET;
            clear_table();
        endfunction

        function void set_buckets(logic [31:0] v);
            int unsigned b;
            b = v[8:0];
            if (b == 0) b = 1;
            if (b > NBUCKET) b = NBUCKET;
            buckets = b;
        endfunction

        function void link_to(int unsigned bkt, int unsigned prev, logic [10:0] tgt);
            if (prev < NPOOL) nlink[prev] = tgt;
            else head[bkt] = tgt;
        endfunction

        // Accepted request: predict and queue the result.
        function void note_request(t_mode mode, logic [31:0] key, logic [31:0] data);
            t_result     r;
            int unsigned bkt, prev, cur, steps, n;
            bit          hit, was_empty;
            r.status     = ST_OK;
            r.found_data = '0;
            if (mode == M_FLUSH) begin
                clear_table();
            end else begin
                bkt   = key % buckets;
                cur   = head[bkt];
                prev  = NIL;
                steps = 0;
                while (cur < NPOOL && steps < NPOOL && nkey[cur] < key) begin
                    prev = cur;
                    cur  = nlink[cur];
                    steps++;
                end
                if (!(cur < NPOOL && steps < NPOOL)) cur = NIL;
                hit = (cur < NPOOL) && (nkey[cur] == key);
                if (mode == M_INSERT) begin
                    if (hit) begin
                        r.status = (nval[cur] == data) ? ST_SAME : ST_DIFFER;
                    end else begin
                        was_empty = (head[bkt] >= NPOOL);
                        if (free_head < NPOOL) begin
                            n = free_head;
                            free_head = nlink[n];
                        end else if (fresh < NPOOL) begin
                            n = fresh++;
                        end else begin
                            n = NIL;
                        end
                        if (n >= NPOOL) begin
                            r.status = ST_FULL;
                        end else begin
                            nkey[n]  = key;
                            nval[n]  = data;
                            nlink[n] = 11'(cur);
                            link_to(bkt, prev, 11'(n));
                            entries++;
                            if (was_empty) used++;
                        end
                    end
                end else if (!hit) begin
                    r.status = ST_MISSING;
                end else begin
                    r.found_data = nval[cur];
                    if (mode == M_REMOVE) begin
                        link_to(bkt, prev, nlink[cur]);
                        nlink[cur] = 11'(free_head);
                        free_head  = cur;
                        if (entries > 0) entries--;
                        if (head[bkt] >= NPOOL && used > 0) used--;
                    end
                end
            end
            r.entry_total      = 11'(entries);
            r.occupied_buckets = 9'(used);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (exp.status <= ST_FULL) status_seen[exp.status]++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.found_data !== exp.found_data) begin
                $error("found_data: expected %h, got %h", exp.found_data, got.found_data);
                errors++;
            end
            if (got.entry_total !== exp.entry_total) begin
                $error("entry_total: expected %0d, got %0d",
                       exp.entry_total, got.entry_total);
                errors++;
            end
            if (got.occupied_buckets !== exp.occupied_buckets) begin
                $error("occupied_buckets: expected %0d, got %0d",
                       exp.occupied_buckets, got.occupied_buckets);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cht_req_if #(.KEY_BITS(32), .DATA_BITS(32)) req ();
    cht_rsp_if #(.DATA_BITS(32), .CNT_W(11), .OCC_W(9)) rsp ();

    chained_hash_table_sorted_chains u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    table_scoreboard sb;
    bit              idle_on;     // random gaps enabled
    bit              hold_req;    // ask the result side for a long stall
    logic [31:0]     key_pool[48];
    logic [31:0]     data_pool[48];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, one long hold on request.
    initial begin
        int      stall;
        t_result got;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_req) begin
                stall    = 300;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
            got.status           = t_status'(rsp.status);
            got.found_data       = rsp.found_data;
            got.entry_total      = rsp.entry_total;
            got.occupied_buckets = rsp.occupied_buckets;
            sb.check_result(got);
        end
    end

    // One request transaction; the transaction is noted at acceptance.
    task automatic send_op(t_mode mode, logic [31:0] key, logic [31:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.key       <= key;
        req.data_word <= data;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(mode, key, data);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of bucket_count, block idle
    task automatic write_buckets(logic [31:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_buckets(v);
    endtask

    task automatic random_op();
        int          pick, idx;
        t_mode       mode;
        logic [31:0] key, data;
        pick = $urandom_range(0, 99);
        if (pick < 42) mode = M_INSERT;
        else if (pick < 68) mode = M_LOOKUP;
        else if (pick < 99) mode = M_REMOVE;
        else mode = M_FLUSH;
        idx  = $urandom_range(0, 47);
        key  = ($urandom_range(0, 4) != 0) ? key_pool[idx] : $urandom;
        data = $urandom_range(0, 1) ? data_pool[idx] : $urandom;
        send_op(mode, key, data);
    endtask

    initial begin
        logic [31:0] cfg_list[9];
        int          ph, i;
        sb = new();
        sb.init();
        idle_on  = 1'b1;
        hold_req = 1'b0;
        cfg_list = '{32'd1, 32'd0, 32'd300, 32'd511, 32'd7, 32'h0000_0207,
                     32'd2, 32'd97, 32'd256};
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 1'b0;
        pwdata        <= '0;
        req.valid     <= 1'b0;
        req.mode      <= M_INSERT;
        req.key       <= '0;
        req.data_word <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: extremes, ordered chain inserts, every status but full ---
        send_op(M_INSERT, 32'd0, 32'd0);
        send_op(M_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(M_INSERT, 32'd512, 32'h1234_5678);   // bucket 0, after key 0
        send_op(M_INSERT, 32'd256, 32'hA5A5_5A5A);   // lands mid-chain
        send_op(M_INSERT, 32'd0, 32'd0);             // same data
        send_op(M_INSERT, 32'd512, 32'd1);           // different data
        send_op(M_LOOKUP, 32'd256, 32'd0);
        send_op(M_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_op(M_LOOKUP, 32'd768, 32'd0);           // miss past chain end
        send_op(M_REMOVE, 32'd256, 32'd0);           // middle node
        send_op(M_REMOVE, 32'd0, 32'd0);             // chain head
        send_op(M_REMOVE, 32'd0, 32'd0);             // already gone
        send_op(M_LOOKUP, 32'd512, 32'd0);
        send_op(M_INSERT, 32'd1024, 32'h8000_0001);  // reuses a freed node
        send_op(M_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(M_LOOKUP, 32'd512, 32'd0);           // empty after flush
        send_op(M_REMOVE, 32'hFFFF_FFFF, 32'd0);

        // --- fill the pool, then overflow ---
        idle_on = 1'b0;
        for (i = 0; i < NPOOL + 4; i++)
            send_op(M_INSERT, 32'(i) * 32'd40503 + 32'h7000_0000, 32'(i) ^ 32'hC3C3_0000);
        send_op(M_INSERT, 32'h7000_0000, 32'hC3C3_0000);  // held key while full
        send_op(M_INSERT, 32'h7000_0000, 32'd5);
        send_op(M_REMOVE, 32'd40503 + 32'h7000_0000, 32'd0);
        send_op(M_INSERT, 32'h0BAD_F00D, 32'h0000_FFFF);   // takes the freed node
        send_op(M_INSERT, 32'h0BAD_F00E, 32'h0000_FFFF);   // full again
        send_op(M_FLUSH, 32'd0, 32'd0);
        idle_on = 1'b1;

        // --- random phases across bucket counts ---
        for (ph = 0; ph < 9; ph++) begin
            foreach (key_pool[k]) begin
                key_pool[k]  = $urandom;
                data_pool[k] = $urandom;
            end
            if (ph % 3 == 2) send_op(M_FLUSH, $urandom, $urandom);
            write_buckets(cfg_list[ph]);
            idle_on = (ph != 4);
            for (i = 0; i < 50; i++) begin
                if (ph == 2 && i == 20) hold_req = 1'b1;
                if (ph == 5 && i == 25) drain();
                random_op();
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        $display("checked %0d results: ok %0d, same %0d, differ %0d, missing %0d, full %0d",
                 sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        $display("covered pool exhaustion and bucket counts 1..256 incl. clamped writes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cht_pkg.sv
rtl/core/cht_if.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dp.sv
rtl/core/chained_hash_table_sorted_chains.sv
verif/chained_hash_table_sorted_chains_tb.sv
